/* rtl/text_terminal_csi_parser_top_assert.svh */
// assertion macros for the csi parser terminal checker
// no dependencies; included by the checker file only
`ifndef TEXT_TERMINAL_CSI_PARSER_TOP_ASSERT_SVH
`define TEXT_TERMINAL_CSI_PARSER_TOP_ASSERT_SVH

// checked outside reset
`define TTCSI_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define TTCSI_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/ttcsi_pkg.sv */
// shared types and constants of the csi parser terminal
// no dependencies; imported by every rtl module but ttcsi_ram
package ttcsi_pkg;

   localparam int BYTE_W      = 8;
   localparam int COLS_CFG_W  = 8;
   localparam int ROWS_CFG_W  = 7;
   localparam int CSR_DATA_W  = 8;
   localparam int CSR_INDEX_W = 1;
   localparam int EFF_COLS_W  = 9;
   localparam int EFF_ROWS_W  = 8;
   localparam int PARAM_W     = 31;

   localparam logic [CSR_INDEX_W-1:0] CSR_COLUMNS = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROWS    = 1'b1;

   localparam logic [COLS_CFG_W-1:0] COLS_RESET = 8'd80;
   localparam logic [ROWS_CFG_W-1:0] ROWS_RESET = 7'd24;

   localparam logic CMD_READ = 1'b1;

   localparam logic [BYTE_W-1:0] CH_LF       = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_CR       = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_ESC      = 8'h1B;
   localparam logic [BYTE_W-1:0] CH_SPACE    = 8'h20;
   localparam logic [BYTE_W-1:0] CH_ZERO     = 8'h30;
   localparam logic [BYTE_W-1:0] CH_NINE     = 8'h39;
   localparam logic [BYTE_W-1:0] CH_FINAL_LO = 8'h40;
   localparam logic [BYTE_W-1:0] CH_UP       = 8'h41;
   localparam logic [BYTE_W-1:0] CH_DOWN     = 8'h42;
   localparam logic [BYTE_W-1:0] CH_RIGHT    = 8'h43;
   localparam logic [BYTE_W-1:0] CH_LEFT     = 8'h44;
   localparam logic [BYTE_W-1:0] CH_CLEAR    = 8'h4A;
   localparam logic [BYTE_W-1:0] CH_LBRACKET = 8'h5B;
   localparam logic [BYTE_W-1:0] CH_TILDE    = 8'h7E;

   // largest value that may still take digit 0..7, and digit 8..9
   localparam logic [PARAM_W-1:0] PARAM_MAX_LO = 31'd214748364;
   localparam logic [PARAM_W-1:0] PARAM_MAX_HI = 31'd214748363;
   localparam logic [PARAM_W-1:0] PARAM_TWO    = 31'd2;

   typedef struct packed {
      logic       cmd;
      logic [7:0] byte_in;
      logic [5:0] read_row;
      logic [6:0] read_col;
   } req_type;

   typedef struct packed {
      logic [7:0] cell_char;
      logic [5:0] cursor_row;
      logic [6:0] cursor_col;
      logic       range_error;
   } rsp_type;

   typedef enum logic [1:0] {
      PS_GROUND,
      PS_ESCAPE,
      PS_CSI
   } parser_state_type;

   typedef enum logic [1:0] {
      CS_CLEAR,
      CS_IDLE,
      CS_EXEC,
      CS_RDWAIT
   } ctrl_state_type;

   typedef struct packed {
      logic load_item;
      logic issue_read;
      logic exec_update;
      logic load_read_rsp;
      logic clr_start;
      logic clr_step;
   } dp_cmd_type;

   typedef struct packed {
      logic item_is_read;
      logic read_in_range;
      logic clear_req;
      logic clr_last;
   } dp_status_type;

endpackage

/* rtl/text_terminal_csi_parser_top.sv */
// feed item or out-of-range read: result register loaded from the execute state, once it is free
// in-range read: loaded from the read wait state, once free, after the registered cell read
// a finished result waits in the output register while the block stays idle for input
// reset (synchronous, active high) starts a sweep of the cell store to spaces, one cell
// per cycle, over all MAX_ROWS*MAX_COLS cells (8192 by default); ESC [ 2 J runs the same sweep
// after its result; input stalls during a sweep, config writes are always taken
module text_terminal_csi_parser_top import ttcsi_pkg::*; #(
   parameter int MAX_COLS = 128,
   parameter int MAX_ROWS = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   // input transaction channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   // result transaction channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   // configuration write channel
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // config registers never back-pressure
   assign csr_ready = 1'b1;

   // sequencing: idle, execute, read wait, clear sweep
   ttcsi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // parser state, cursor, config registers, cell store and result register
   ttcsi_dp #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .csr_we    (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

/* rtl/ttcsi_ram.sv */
// generic single write, single read ram with registered read data
// no dependencies
module ttcsi_ram #(
   parameter  int WIDTH = 8,
   parameter  int DEPTH = 16,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/ttcsi_ctrl.sv */
// controller state machine of the csi parser terminal
// depends on ttcsi_pkg
module ttcsi_ctrl import ttcsi_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_free;

   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CS_CLEAR: begin
            if (status.clr_last) state_in = CS_IDLE;
         end
         CS_IDLE: begin
            if (req_valid) state_in = CS_EXEC;
         end
         CS_EXEC: begin
            if (status.item_is_read && status.read_in_range) begin
               state_in = CS_RDWAIT;
            end else if (rsp_free) begin
               state_in = status.clear_req ? CS_CLEAR : CS_IDLE;
            end
         end
         CS_RDWAIT: begin
            if (rsp_free) state_in = CS_IDLE;
         end
         default: state_in = CS_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         CS_CLEAR: begin
            cmd.clr_step = 1'b1;
         end
         CS_IDLE: begin
            req_stall     = 1'b0;
            cmd.load_item = req_valid;
         end
         CS_EXEC: begin
            if (status.item_is_read && status.read_in_range) begin
               cmd.issue_read = 1'b1;
            end else if (rsp_free) begin
               cmd.exec_update = 1'b1;
               cmd.clr_start   = status.clear_req;
            end
         end
         CS_RDWAIT: begin
            cmd.load_read_rsp = rsp_free;
         end
         default: ;
      endcase
   end

   always_comb begin
      if (cmd.exec_update || cmd.load_read_rsp) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CS_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

/* rtl/ttcsi_dp.sv */
// datapath of the csi parser terminal: parser, cursor, config and cell store
// depends on ttcsi_pkg and ttcsi_ram
module ttcsi_dp import ttcsi_pkg::*; #(
   parameter int MAX_COLS = 128,
   parameter int MAX_ROWS = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  req_type                req_data,
   output rsp_type                rsp_data,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  dp_cmd_type             cmd,
   output dp_status_type          status
);

   localparam int RWID  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CWID  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int DEPTH = MAX_ROWS * MAX_COLS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW    = ((RWID > CWID) ? RWID : CWID) + 1;
   localparam int SW    = (NW + 1 > EFF_COLS_W) ? NW + 1 : EFF_COLS_W;
   localparam int PW    = EFF_ROWS_W + EFF_COLS_W;
   localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

   function automatic logic [EFF_COLS_W-1:0] sat_cols(input logic [COLS_CFG_W-1:0] v);
      if (v == '0) return EFF_COLS_W'(1);
      if (EFF_COLS_W'(v) > EFF_COLS_W'(MAX_COLS)) return EFF_COLS_W'(MAX_COLS);
      return EFF_COLS_W'(v);
   endfunction

   function automatic logic [EFF_ROWS_W-1:0] sat_rows(input logic [ROWS_CFG_W-1:0] v);
      if (v == '0) return EFF_ROWS_W'(1);
      if (EFF_ROWS_W'(v) > EFF_ROWS_W'(MAX_ROWS)) return EFF_ROWS_W'(MAX_ROWS);
      return EFF_ROWS_W'(v);
   endfunction

   req_type             item_ff;
   rsp_type             rsp_ff, rsp_in;
   logic [COLS_CFG_W-1:0] cols_cfg_ff, cols_cfg_in;
   logic [ROWS_CFG_W-1:0] rows_cfg_ff, rows_cfg_in;
   parser_state_type    pstate_ff, pstate_in, pstate_nx;
   logic [PARAM_W-1:0]  pval_ff, pval_in, pval_nx;
   logic                ppres_ff, ppres_in, ppres_nx;
   logic                povf_ff, povf_in, povf_nx;
   logic [RWID-1:0]     crow_ff, crow_in, crow_nx;
   logic [CWID-1:0]     ccol_ff, ccol_in, ccol_nx;
   logic [AW-1:0]       clr_cnt_ff, clr_cnt_in;

   logic [EFF_COLS_W-1:0] eff_cols, new_eff_cols;
   logic [EFF_ROWS_W-1:0] eff_rows, new_eff_rows;
   logic [BYTE_W-1:0]     b;
   logic                  is_read, feed_update, cell_wr;
   logic                  row_inc_ok;
   logic [EFF_COLS_W-1:0] col_inc;
   logic [3:0]            digit;
   logic                  digit_ovf;
   logic [PARAM_W-1:0]    pval_dec;
   logic                  param_is_two;
   logic [NW-1:0]         n_move;
   logic [SW-1:0]         row_max_s, col_max_s, down_sum, right_sum;
   logic [RWID-1:0]       up_row, down_row;
   logic [CWID-1:0]       right_col, left_col;
   logic [EFF_ROWS_W-1:0] row_op;
   logic [EFF_COLS_W-1:0] col_op;
   logic [PW-1:0]         row_base;
   logic [AW-1:0]         cell_addr;
   logic                  ram_we;
   logic [AW-1:0]         ram_waddr;
   logic [BYTE_W-1:0]     ram_wdata, ram_rdata;

   assign eff_cols = sat_cols(cols_cfg_ff);
   assign eff_rows = sat_rows(rows_cfg_ff);
   assign new_eff_cols = (csr_index == CSR_COLUMNS) ? sat_cols(csr_wdata) : eff_cols;
   assign new_eff_rows = (csr_index == CSR_ROWS) ? sat_rows(csr_wdata[ROWS_CFG_W-1:0])
                                                 : eff_rows;

   assign b           = item_ff.byte_in;
   assign is_read     = (item_ff.cmd == CMD_READ);
   assign feed_update = cmd.exec_update && !is_read;

   // single shared row * stride + col address
   assign row_op    = is_read ? EFF_ROWS_W'(item_ff.read_row) : EFF_ROWS_W'(crow_ff);
   assign col_op    = is_read ? EFF_COLS_W'(item_ff.read_col) : EFF_COLS_W'(ccol_ff);
   assign row_base  = row_op * eff_cols;
   assign cell_addr = AW'(row_base + PW'(col_op));

   assign row_inc_ok = (EFF_ROWS_W'(crow_ff) + 1'b1) < eff_rows;
   assign col_inc    = EFF_COLS_W'(ccol_ff) + 1'b1;

   // decimal parameter accumulation
   assign digit     = b[3:0];
   assign digit_ovf = (pval_ff > PARAM_MAX_LO) || ((digit >= 4'd8) && (pval_ff > PARAM_MAX_HI));
   assign pval_dec  = PARAM_W'({pval_ff, 3'b000}) + PARAM_W'({pval_ff, 1'b0}) + PARAM_W'(digit);
   assign param_is_two = ppres_ff && !povf_ff && (pval_ff == PARAM_TWO);

   // move count: default 1, saturated above any screen size
   always_comb begin
      if (!ppres_ff || povf_ff || (pval_ff == '0)) begin
         n_move = NW'(1);
      end else if ((pval_ff >> NW) != '0) begin
         n_move = '1;
      end else begin
         n_move = NW'(pval_ff);
      end
   end

   assign row_max_s = SW'(eff_rows) - 1'b1;
   assign col_max_s = SW'(eff_cols) - 1'b1;
   assign down_sum  = SW'(crow_ff) + SW'(n_move);
   assign right_sum = SW'(ccol_ff) + SW'(n_move);
   assign up_row    = (n_move >= NW'(crow_ff)) ? '0 : RWID'(NW'(crow_ff) - n_move);
   assign left_col  = (n_move >= NW'(ccol_ff)) ? '0 : CWID'(NW'(ccol_ff) - n_move);
   assign down_row  = (down_sum > row_max_s) ? RWID'(row_max_s) : RWID'(down_sum);
   assign right_col = (right_sum > col_max_s) ? CWID'(col_max_s) : CWID'(right_sum);

   // parser step for one fed byte
   always_comb begin
      pstate_nx = pstate_ff;
      pval_nx   = pval_ff;
      ppres_nx  = ppres_ff;
      povf_nx   = povf_ff;
      crow_nx   = crow_ff;
      ccol_nx   = ccol_ff;
      cell_wr   = 1'b0;
      case (pstate_ff)
         PS_GROUND: begin
            if (b == CH_ESC) begin
               pstate_nx = PS_ESCAPE;
            end else if (b == CH_LF) begin
               if (row_inc_ok) crow_nx = crow_ff + 1'b1;
            end else if (b == CH_CR) begin
               ccol_nx = '0;
            end else if (b inside {[CH_SPACE:CH_TILDE]}) begin
               cell_wr = 1'b1;
               if (col_inc >= eff_cols) begin
                  ccol_nx = '0;
                  if (row_inc_ok) crow_nx = crow_ff + 1'b1;
               end else begin
                  ccol_nx = CWID'(col_inc);
               end
            end
         end
         PS_ESCAPE: begin
            if (b == CH_LBRACKET) begin
               pstate_nx = PS_CSI;
               pval_nx   = '0;
               ppres_nx  = 1'b0;
               povf_nx   = 1'b0;
            end else begin
               pstate_nx = PS_GROUND;
            end
         end
         default: begin
            if (b inside {[CH_ZERO:CH_NINE]}) begin
               ppres_nx = 1'b1;
               if (!povf_ff) begin
                  if (digit_ovf) povf_nx = 1'b1;
                  else           pval_nx = pval_dec;
               end
            end else if (b inside {[CH_FINAL_LO:CH_TILDE]}) begin
               pstate_nx = PS_GROUND;
               pval_nx   = '0;
               ppres_nx  = 1'b0;
               povf_nx   = 1'b0;
               case (b)
                  CH_UP:    crow_nx = up_row;
                  CH_DOWN:  crow_nx = down_row;
                  CH_RIGHT: ccol_nx = right_col;
                  CH_LEFT:  ccol_nx = left_col;
                  CH_CLEAR: begin
                     if (param_is_two) begin
                        crow_nx = '0;
                        ccol_nx = '0;
                     end
                  end
                  default: ;
               endcase
            end
         end
      endcase
   end

   assign status.item_is_read  = is_read;
   assign status.read_in_range = (EFF_ROWS_W'(item_ff.read_row) < eff_rows) &&
                                 (EFF_COLS_W'(item_ff.read_col) < eff_cols);
   assign status.clear_req     = !is_read && (pstate_ff == PS_CSI) && (b == CH_CLEAR) &&
                                 param_is_two;
   assign status.clr_last      = (clr_cnt_ff == LAST_ADDR);

   always_comb begin
      cols_cfg_in = cols_cfg_ff;
      rows_cfg_in = rows_cfg_ff;
      crow_in     = crow_ff;
      ccol_in     = ccol_ff;
      pstate_in   = pstate_ff;
      pval_in     = pval_ff;
      ppres_in    = ppres_ff;
      povf_in     = povf_ff;
      if (feed_update) begin
         pstate_in = pstate_nx;
         pval_in   = pval_nx;
         ppres_in  = ppres_nx;
         povf_in   = povf_nx;
      end
      if (csr_we) begin
         if (csr_index == CSR_COLUMNS) cols_cfg_in = csr_wdata;
         if (csr_index == CSR_ROWS)    rows_cfg_in = csr_wdata[ROWS_CFG_W-1:0];
         if (EFF_ROWS_W'(crow_ff) >= new_eff_rows) crow_in = RWID'(new_eff_rows - 1'b1);
         if (EFF_COLS_W'(ccol_ff) >= new_eff_cols) ccol_in = CWID'(new_eff_cols - 1'b1);
      end else if (feed_update) begin
         crow_in = crow_nx;
         ccol_in = ccol_nx;
      end
   end

   always_comb begin
      clr_cnt_in = clr_cnt_ff;
      if (cmd.clr_start)     clr_cnt_in = '0;
      else if (cmd.clr_step) clr_cnt_in = clr_cnt_ff + 1'b1;
   end

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.load_read_rsp) begin
         rsp_in.cell_char   = ram_rdata;
         rsp_in.cursor_row  = 6'(crow_ff);
         rsp_in.cursor_col  = 7'(ccol_ff);
         rsp_in.range_error = 1'b0;
      end else if (cmd.exec_update) begin
         rsp_in.cell_char   = '0;
         rsp_in.cursor_row  = is_read ? 6'(crow_ff) : 6'(crow_nx);
         rsp_in.cursor_col  = is_read ? 7'(ccol_ff) : 7'(ccol_nx);
         rsp_in.range_error = is_read;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_cfg_ff <= COLS_RESET;
         rows_cfg_ff <= ROWS_RESET;
         pstate_ff   <= PS_GROUND;
         pval_ff     <= '0;
         ppres_ff    <= 1'b0;
         povf_ff     <= 1'b0;
         crow_ff     <= '0;
         ccol_ff     <= '0;
         clr_cnt_ff  <= '0;
      end else begin
         cols_cfg_ff <= cols_cfg_in;
         rows_cfg_ff <= rows_cfg_in;
         pstate_ff   <= pstate_in;
         pval_ff     <= pval_in;
         ppres_ff    <= ppres_in;
         povf_ff     <= povf_in;
         crow_ff     <= crow_in;
         ccol_ff     <= ccol_in;
         clr_cnt_ff  <= clr_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) item_ff <= req_data;
      rsp_ff <= rsp_in;
   end

   assign rsp_data = rsp_ff;

   // sweep writes spaces, otherwise a printable byte lands at the cursor
   assign ram_we    = cmd.clr_step || (feed_update && cell_wr);
   assign ram_waddr = cmd.clr_step ? clr_cnt_ff : cell_addr;
   assign ram_wdata = cmd.clr_step ? CH_SPACE : b;

   ttcsi_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (DEPTH)
   ) u_cells (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (cmd.issue_read),
      .rd_addr (cell_addr),
      .rd_data (ram_rdata)
   );

endmodule

/* rtl/ttcsi_checker.sv */
// port-level checks of the csi parser terminal, bound to the top level
// depends on ttcsi_pkg and text_terminal_csi_parser_top_assert.svh
`include "text_terminal_csi_parser_top_assert.svh"

module ttcsi_checker import ttcsi_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // a stalled result holds
   `TTCSI_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data), "stalled result changed")

   // one transaction at a time
   `TTCSI_ASSERT(a_one_item, clock, reset, req_valid && !req_stall |=> req_stall, "input taken while busy")

   // reset starts the store sweep, so input is held off
   `TTCSI_ASSERT_ALWAYS(a_reset_stall, clock, $past(reset) |-> req_stall, "input open right after reset")

   // a range error never carries a character
   `TTCSI_ASSERT(a_err_char, clock, reset, rsp_valid && rsp_data.range_error |-> rsp_data.cell_char == 8'h00, "range error with character")

endmodule

bind text_terminal_csi_parser_top ttcsi_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

/* test/tb_text_terminal_csi_parser_top.sv */
// self-checking testbench for the csi parser terminal: directed and random byte streams
// and cell reads, checked against a cycle-free screen model kept inside this module
// depends on ttcsi_pkg and text_terminal_csi_parser_top only
`timescale 1ns / 100ps

module tb_text_terminal_csi_parser_top;
   import ttcsi_pkg::*;

   localparam int SCREEN_MAX_COLS = 128;
   localparam int SCREEN_MAX_ROWS = 64;
   localparam int SCREEN_CELLS    = SCREEN_MAX_COLS * SCREEN_MAX_ROWS;
   localparam longint unsigned PARAM_CEILING = 64'd2147483647;

   localparam logic CMD_FEED = ~CMD_READ;
   localparam logic [7:0] CH_SEMI = 8'h3B;
   localparam logic [7:0] CH_DEL  = 8'h7F;

   localparam int TOTAL_ITEMS  = 1850;
   localparam int RANDOM_PHASES = 10;
   localparam int MAX_CLEARS   = 24;   // each clear costs a full sweep of the store
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_TAIL   = 20;
   localparam int MAX_REPORTS  = 40;

   // screen settings per random phase, extremes first; rows data above 127 checks the mask
   localparam logic [7:0] PHASE_COLS [RANDOM_PHASES] =
      '{8'd128, 8'd1, 8'd255, 8'd0, 8'd5, 8'd16, 8'd129, 8'd80, 8'd40, 8'd2};
   localparam logic [7:0] PHASE_ROWS [RANDOM_PHASES] =
      '{8'd64, 8'd1, 8'd127, 8'd200, 8'd3, 8'd6, 8'd65, 8'd24, 8'd12, 8'd64};

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;
   always #6 clock = ~clock;

   // block ports, all inputs known from time zero
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_COLUMNS;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   text_terminal_csi_parser_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // screen model: cells, cursor, escape parser and the two screen registers
   logic [7:0]       shadow_cells [SCREEN_CELLS];
   int unsigned      shadow_row = 0;
   int unsigned      shadow_col = 0;
   parser_state_type parse_mode = PS_GROUND;
   longint unsigned  param_acc  = 0;
   bit               param_seen = 1'b0;
   bit               param_big  = 1'b0;
   logic [7:0]       shadow_cols_cfg = COLS_RESET;
   logic [6:0]       shadow_rows_cfg = ROWS_RESET;

   // results still owed by the block, oldest first
   rsp_type awaited_readouts [$];

   // run bookkeeping
   int  n_fail     = 0;
   int  n_items    = 0;
   int  n_reads    = 0;
   int  n_clears   = 0;
   int  n_settings = 0;
   bit  idle_on    = 1'b1;
   int  hold_req_cnt = 0;

   // ---------------------------------------------------------------------------
   // screen model
   // ---------------------------------------------------------------------------

   // register values saturate into the real screen size
   function automatic int unsigned screen_cols();
      if (shadow_cols_cfg < 1) return 1;
      if (shadow_cols_cfg > SCREEN_MAX_COLS) return SCREEN_MAX_COLS;
      return shadow_cols_cfg;
   endfunction

   function automatic int unsigned screen_rows();
      if (shadow_rows_cfg < 1) return 1;
      if (shadow_rows_cfg > SCREEN_MAX_ROWS) return SCREEN_MAX_ROWS;
      return shadow_rows_cfg;
   endfunction

   // a smaller screen pulls the cursor back inside
   function automatic void clamp_cursor_to_screen();
      if (shadow_row >= screen_rows()) shadow_row = screen_rows() - 1;
      if (shadow_col >= screen_cols()) shadow_col = screen_cols() - 1;
   endfunction

   // apply one transaction to the model and return the result it must produce
   function automatic rsp_type compute_readout(input req_type it);
      rsp_type         r;
      int unsigned     rows;
      int unsigned     cols;
      int unsigned     d;
      longint unsigned n;
      logic [7:0]      b;
      rows = screen_rows();
      cols = screen_cols();
      b    = it.byte_in;
      r    = '0;
      if (it.cmd == CMD_READ) begin
         if (it.read_row >= rows || it.read_col >= cols) begin
            r.range_error = 1'b1;
         end else begin
            // row-major with the stride of the columns in use
            r.cell_char = shadow_cells[it.read_row * cols + it.read_col];
         end
      end else begin
         case (parse_mode)
            PS_GROUND: begin
               if (b == CH_ESC) begin
                  parse_mode = PS_ESCAPE;
               end else if (b == CH_LF) begin
                  if (shadow_row + 1 < rows) shadow_row++;
               end else if (b == CH_CR) begin
                  shadow_col = 0;
               end else if (b >= CH_SPACE && b < CH_DEL) begin
                  shadow_cells[shadow_row * cols + shadow_col] = b;
                  shadow_col++;
                  // wrap to the next row but never scroll
                  if (shadow_col >= cols) begin
                     shadow_col = 0;
                     if (shadow_row + 1 < rows) shadow_row++;
                  end
               end
            end
            PS_ESCAPE: begin
               if (b == CH_LBRACKET) begin
                  param_acc  = 0;
                  param_seen = 1'b0;
                  param_big  = 1'b0;
                  parse_mode = PS_CSI;
               end else begin
                  parse_mode = PS_GROUND;
               end
            end
            default: begin
               if (b >= CH_ZERO && b <= CH_NINE) begin
                  d = b - CH_ZERO;
                  param_seen = 1'b1;
                  if (!param_big) begin
                     if (param_acc > (PARAM_CEILING - d) / 10) param_big = 1'b1;
                     else param_acc = param_acc * 10 + d;
                  end
               end else if (b >= CH_FINAL_LO && b <= CH_TILDE) begin
                  // overflowed or missing parameter counts as absent, zero moves by one
                  n = (param_seen && !param_big) ? param_acc : 1;
                  if (n < 1) n = 1;
                  case (b)
                     CH_UP:    shadow_row = (n >= shadow_row) ? 0 : shadow_row - n;
                     CH_DOWN:  shadow_row = (shadow_row + n > rows - 1) ? rows - 1 : shadow_row + n;
                     CH_RIGHT: shadow_col = (shadow_col + n > cols - 1) ? cols - 1 : shadow_col + n;
                     CH_LEFT:  shadow_col = (n >= shadow_col) ? 0 : shadow_col - n;
                     CH_CLEAR: begin
                        if (param_seen && !param_big && param_acc == 2) begin
                           foreach (shadow_cells[i]) shadow_cells[i] = CH_SPACE;
                           shadow_row = 0;
                           shadow_col = 0;
                           n_clears++;
                        end
                     end
                     default: ;
                  endcase
                  parse_mode = PS_GROUND;
                  param_acc  = 0;
                  param_seen = 1'b0;
                  param_big  = 1'b0;
               end
               // semicolons and other bytes leave the parameter untouched
            end
         endcase
      end
      r.cursor_row = shadow_row[5:0];
      r.cursor_col = shadow_col[6:0];
      return r;
   endfunction

   // ---------------------------------------------------------------------------
   // result side: random stalls, one long hold-off on request, and the checker
   // ---------------------------------------------------------------------------

   int hold_seen = 0;
   int hold_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_seen != hold_req_cnt) begin
         // start of a long hold-off, counted down here
         hold_seen = hold_req_cnt;
         hold_left = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= idle_on && ($urandom_range(0, 99) < 13);
      end
   end

   task automatic report_field(input string field, input logic [7:0] want,
                               input logic [7:0] got);
      n_fail++;
      if (n_fail <= MAX_REPORTS)
         $display("%0t ns: %s mismatch, expected %h, actual %h", $time, field, want, got);
   endtask

   // values read here are the ones from before this edge, so no ordering race
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_readouts.size() == 0) begin
            n_fail++;
            if (n_fail <= MAX_REPORTS)
               $display("%0t ns: result transaction with none expected, actual %h",
                        $time, rsp_data);
         end else begin
            want = awaited_readouts.pop_front();
            if (rsp_data.cell_char !== want.cell_char)
               report_field("cell_char", want.cell_char, rsp_data.cell_char);
            if (rsp_data.cursor_row !== want.cursor_row)
               report_field("cursor_row", want.cursor_row, rsp_data.cursor_row);
            if (rsp_data.cursor_col !== want.cursor_col)
               report_field("cursor_col", want.cursor_col, rsp_data.cursor_col);
            if (rsp_data.range_error !== want.range_error)
               report_field("range_error", want.range_error, rsp_data.range_error);
         end
      end
   end

   // ---------------------------------------------------------------------------
   // input side
   // ---------------------------------------------------------------------------

   // offer one transaction, at times after a random gap, and predict it once taken
   task automatic send_item(input req_type it);
      if (idle_on && $urandom_range(0, 99) < 13) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (req_stall);
      awaited_readouts.insert(awaited_readouts.size(), compute_readout(it));
      n_items++;
      if (it.cmd == CMD_READ) n_reads++;
   endtask

   // unused fields carry random bits so every input bit toggles
   task automatic send_feed(input logic [7:0] b);
      req_type it;
      it.cmd      = CMD_FEED;
      it.byte_in  = b;
      it.read_row = $urandom_range(0, 63);
      it.read_col = $urandom_range(0, 127);
      send_item(it);
   endtask

   task automatic send_read(input int unsigned r, input int unsigned c);
      req_type it;
      it.cmd      = CMD_READ;
      it.byte_in  = $urandom_range(0, 255);
      it.read_row = r;
      it.read_col = c;
      send_item(it);
   endtask

   task automatic open_csi();
      send_feed(CH_ESC);
      send_feed(CH_LBRACKET);
   endtask

   // decimal digits of a parameter, optionally broken up by semicolons
   task automatic send_number(input longint unsigned v, input bit split);
      string s;
      s = $sformatf("%0d", v);
      for (int i = 0; i < s.len(); i++) begin
         if (split && $urandom_range(0, 2) == 0) send_feed(CH_SEMI);
         send_feed(s[i]);
      end
   endtask

   // a byte the csi state ignores: not a digit, not a semicolon, not a final byte
   task automatic send_csi_filler();
      logic [7:0] b;
      do b = $urandom_range(0, 255);
      while ((b >= CH_ZERO && b <= CH_NINE) || b == CH_SEMI ||
             (b >= CH_FINAL_LO && b <= CH_TILDE));
      send_feed(b);
   endtask

   // pull valid down, wait for every owed result, then for any sweep to end
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (awaited_readouts.size() != 0) @(posedge clock);
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // write both screen registers back to back; only called with the block idle
   task automatic set_screen(input logic [7:0] cols_val, input logic [7:0] rows_val);
      csr_valid <= 1'b1;
      csr_index <= CSR_COLUMNS;
      csr_wdata <= cols_val;
      do @(posedge clock); while (!csr_ready);
      shadow_cols_cfg = cols_val;
      clamp_cursor_to_screen();
      csr_index <= CSR_ROWS;
      csr_wdata <= rows_val;
      do @(posedge clock); while (!csr_ready);
      shadow_rows_cfg = rows_val[6:0];
      clamp_cursor_to_screen();
      csr_valid <= 1'b0;
      n_settings++;
   endtask

   // well-formed csi sequence with random parameter and final byte
   task automatic send_csi();
      longint unsigned v;
      bit              has_param;
      bit              split;
      int              pk;
      int              fk;
      logic [7:0]      fin;
      pk        = $urandom_range(0, 99);
      split     = ($urandom_range(0, 3) == 0);
      has_param = (pk >= 20);
      if (pk < 75)      v = $urandom_range(0, 12);
      else if (pk < 88) v = $urandom_range(13, 300);
      else if (pk < 95) v = 64'd2147483648 + $urandom;           // always overflows
      else              v = PARAM_CEILING - 1 + $urandom_range(0, 3); // around the limit
      fk = $urandom_range(0, 99);
      if (fk < 70) begin
         fin = CH_UP + $urandom_range(0, 3);
      end else if (fk < 85) begin
         fin = CH_CLEAR;
         // clears are rationed, the sweep behind each one is long
         if (n_clears < MAX_CLEARS && $urandom_range(0, 1) == 1) begin
            has_param = 1'b1;
            v = 2;
         end else if (has_param && v == 2) begin
            v = 3;
         end
      end else begin
         do fin = $urandom_range(CH_FINAL_LO, CH_TILDE);
         while ((fin >= CH_UP && fin <= CH_LEFT) || fin == CH_CLEAR);
      end
      open_csi();
      if ($urandom_range(0, 5) == 0) send_csi_filler();
      if (has_param) send_number(v, split);
      if ($urandom_range(0, 5) == 0) send_feed(CH_SEMI);
      if ($urandom_range(0, 7) == 0) send_csi_filler();
      send_feed(fin);
   endtask

   // ---------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------

   // screen after the reset sweep at the default 80 x 24 size, edges of the range
   task automatic test_reset_screen();
      send_read(0, 0);
      send_read(23, 79);
      send_read(24, 0);
      send_read(0, 80);
      send_read(63, 127);
   endtask

   // both registers zero saturate to a single cell: write wraps in place, lf clamps
   task automatic test_tiny_screen();
      wait_drained();
      set_screen(8'd0, 8'd0);
      send_feed("Z");
      send_feed(CH_LF);
      send_read(0, 0);
      send_read(0, 1);
   endtask

   // full-size screen from out-of-range register values, printable filter, bare escape
   task automatic test_byte_filter();
      wait_drained();
      set_screen(8'd255, 8'd255);
      send_feed(CH_SPACE);
      send_feed(CH_TILDE);
      send_feed(CH_DEL);
      send_feed(8'hFF);
      send_feed(8'h00);
      send_feed(CH_ESC);
      send_feed("q");
      send_read(0, 1);
      send_read(63, 127);
   endtask

   // joined digits, filler inside csi, zero and missing parameter, unknown final,
   // overflow, j with another parameter, then the real clear
   task automatic test_csi_sequences();
      open_csi();
      send_feed("1");
      send_feed(CH_SEMI);
      send_feed("5");
      send_feed("!");
      send_feed(CH_DOWN);
      open_csi();
      send_feed(CH_ZERO);
      send_feed(CH_RIGHT);
      open_csi();
      send_feed(CH_TILDE);
      open_csi();
      send_number(64'd9999999999, 1'b0);
      send_feed(CH_UP);
      open_csi();
      send_feed("1");
      send_feed(CH_CLEAR);
      send_read(0, 1);
      open_csi();
      send_feed("2");
      send_feed(CH_CLEAR);
      send_read(0, 1);
   endtask

   // receiver holds off for a long stretch while the sender keeps offering,
   // so the result register fills and input stalls
   task automatic test_receiver_backpressure();
      wait_drained();
      idle_on = 1'b0;
      hold_req_cnt++;
      repeat (24) begin
         if ($urandom_range(0, 3) == 0) send_read(shadow_row, $urandom_range(0, 127));
         else send_feed($urandom_range(CH_SPACE, CH_TILDE));
      end
      wait_drained();
      idle_on = 1'b1;
   endtask

   // random traffic over a series of screen settings, the sender pausing in between
   task automatic test_random_traffic();
      int         phase_end;
      int         sel;
      logic [7:0] cols_val;
      logic [7:0] rows_val;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         wait_drained();
         cols_val = PHASE_COLS[p];
         rows_val = PHASE_ROWS[p];
         if (p == 5) begin
            cols_val = $urandom_range(1, 24);
            rows_val = $urandom_range(1, 12) | ($urandom_range(0, 1) << 7);
         end
         if (p == 7) begin
            cols_val = $urandom_range(0, 255);
            rows_val = $urandom_range(0, 255);
         end
         set_screen(cols_val, rows_val);
         // one phase runs with no gaps and no stalls at all
         idle_on   = (p != 6);
         phase_end = n_items + (TOTAL_ITEMS - n_items) / (RANDOM_PHASES - p);
         while (n_items < phase_end) begin
            sel = $urandom_range(0, 99);
            if (sel < 30) begin
               repeat ($urandom_range(1, 6)) send_feed($urandom_range(CH_SPACE, CH_TILDE));
            end else if (sel < 38) begin
               send_feed($urandom_range(0, 1) ? CH_LF : CH_CR);
            end else if (sel < 65) begin
               send_csi();
            end else if (sel < 80) begin
               // mostly near the cursor, where the text is
               send_read((shadow_row > 0 && $urandom_range(0, 1)) ? shadow_row - 1 : shadow_row,
                         $urandom_range(0, screen_cols() - 1));
            end else if (sel < 86) begin
               send_read($urandom_range(0, 63), $urandom_range(0, 127));
            end else if (sel < 94) begin
               send_feed($urandom_range(0, 255));
            end else begin
               // escape that may or may not become a sequence
               send_feed(CH_ESC);
               send_feed($urandom_range(0, 255));
            end
         end
      end
      idle_on = 1'b1;
   endtask

   // ---------------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------------

   initial begin
      foreach (shadow_cells[i]) shadow_cells[i] = CH_SPACE;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      // the block sweeps its store after reset; the first send waits on stall
      test_reset_screen();
      test_tiny_screen();
      test_byte_filter();
      test_csi_sequences();
      test_receiver_backpressure();
      test_random_traffic();
      wait_drained();
      repeat (DRAIN_TAIL) @(posedge clock);
      $display("covered %0d transactions (%0d cell reads) over %0d screen settings",
               n_items, n_reads, n_settings);
      $display("with %0d full clears, one long receiver hold-off, %0d mismatches",
               n_clears, n_fail);
      if (n_fail == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // hard stop well beyond the slowest correct run
   initial begin
      #30_000_000;
      $display("%0t ns: timeout, %0d results still owed", $time, awaited_readouts.size());
      $display("Simulation FAILED");
      $finish;
   end

endmodule
